// ----- design/mhtq_pkg.sv -----
// Package for the min-heap timer queue: sizes, command and error codes,
// sequencer state type. No dependencies.
package mhtq_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int ID_SPACE_DEF = 1024;

  localparam int CMD_W   = 3;
  localparam int ID_W    = 10;
  localparam int TMO_W   = 24;
  localparam int EXP_W   = 32;
  localparam int ERR_W   = 2;

  localparam logic [TMO_W-1:0] DELAY_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_SCHED   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RESCHED = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIRE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNKNOWN = 2'd2;

  localparam logic KIND_NOTICE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LOOK, S_CHK,
    S_SD, S_SD1, S_SD2, S_SD3,
    S_SU, S_SU1, S_RM0, S_RM1,
    S_TICK, S_TK1, S_STAT, S_ST1
  } state_t;

endpackage

// ----- design/min_heap_timer_queue.sv -----
// Timer queue top level: binary min-heap of (id, expiry) with id-to-slot map.
// Lookup reads the map entry, then the heap slot; a sift moves one heap level per step.
// Schedule/reschedule look up, then sift; a tick removes and re-sifts each due timer.
// One command in flight; busy drops in the cycle the final status is shown.
// Reset: synchronous; then a map-clear pass over all ID_SPACE entries with busy high.
// Results are registered, one cycle each, and cannot be stalled.
module min_heap_timer_queue
  import mhtq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int ID_SPACE = ID_SPACE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [ID_W-1:0]    timer_id,
  input  logic [TMO_W-1:0]   timeout_ms,
  output logic               valid,
  output logic               kind,
  output logic [ID_W-1:0]    fired_id,
  output logic [TMO_W-1:0]   next_delay_ms,
  output logic               queue_empty,
  output logic [ERR_W-1:0]   error,
  output logic               last
);

  localparam int AW = $clog2(CAPACITY);      // heap slot address
  localparam int MW = $clog2(CAPACITY + 1);  // count / map entry (all ones = none)
  localparam int IW = $clog2(ID_SPACE);      // map address
  localparam int HW = ID_W + EXP_W;          // heap word: {id, expiry}

  state_t state, state_next;

  // latched transaction
  logic [CMD_W-1:0] cmd_r;
  logic [ID_W-1:0]  id_r;
  logic [TMO_W-1:0] tmo_r;
  logic [ERR_W-1:0] err_r;

  logic [MW-1:0]    count;
  logic [EXP_W-1:0] now;
  logic [IW-1:0]    clr_cnt;

  // moving item (hole method) and current hole position
  logic [AW-1:0]    pos, start_pos;
  logic [ID_W-1:0]  item_id;
  logic [EXP_W-1:0] item_exp;
  // best child found so far during sift-down
  logic [AW-1:0]    cand_pos;
  logic [ID_W-1:0]  cand_id;
  logic [EXP_W-1:0] cand_exp;

  // memories
  logic          heap_we;
  logic [AW-1:0] heap_waddr, heap_raddr;
  logic [HW-1:0] heap_wdata, heap_q;
  logic          map_we;
  logic [IW-1:0] map_waddr, map_raddr;
  logic [MW-1:0] map_wdata, map_q;

  mhtq_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap (
    .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
    .raddr(heap_raddr), .rdata(heap_q)
  );

  mhtq_ram #(.WIDTH(MW), .DEPTH(ID_SPACE)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_q)
  );

  logic [ID_W-1:0]  hq_id;
  logic [EXP_W-1:0] hq_exp;
  assign hq_id  = heap_q[HW-1:EXP_W];
  assign hq_exp = heap_q[EXP_W-1:0];

  // id is pending when its map entry points inside the heap at a slot holding it
  logic id_ok, found;
  assign id_ok = (int'(id_r) < ID_SPACE);
  assign found = id_ok && (map_q < count) && (hq_id == id_r);

  // child / parent indexes
  logic [AW+1:0] lc_w, rc_w, count_w;
  logic          lc_ok, rc_ok;
  logic [AW-1:0] pos_m1, parent;
  logic [MW-1:0] count_m1;
  assign lc_w     = (AW+2)'({pos, 1'b1});
  assign rc_w     = lc_w + (AW+2)'(1);
  assign count_w  = (AW+2)'(count);
  assign lc_ok    = lc_w < count_w;
  assign rc_ok    = rc_w < count_w;
  assign pos_m1   = pos - AW'(1);
  assign parent   = pos_m1 >> 1;
  assign count_m1 = count - MW'(1);

  logic moved;
  assign moved = (pos != start_pos);

  // shared subtract/compare unit: diff = a - b, earlier when negative
  logic [EXP_W-1:0] cmp_a, cmp_b, diff;
  logic             earlier;
  always_comb begin
    case (state)
      S_SD2: begin
        cmp_a = hq_exp;
        cmp_b = cand_exp;
      end
      S_SD3: begin
        cmp_a = item_exp;
        cmp_b = cand_exp;
      end
      S_SU1: begin
        cmp_a = hq_exp;
        cmp_b = item_exp;
      end
      default: begin
        cmp_a = hq_exp;
        cmp_b = now;
      end
    endcase
  end
  assign diff    = cmp_a - cmp_b;
  assign earlier = diff[EXP_W-1];

  logic due;
  assign due = (diff == '0) || diff[EXP_W-1];

  logic [TMO_W-1:0] delay_clamp;
  always_comb begin
    if (diff[EXP_W-1]) begin
      delay_clamp = '0;
    end else if (|diff[EXP_W-1:TMO_W]) begin
      delay_clamp = DELAY_MAX;
    end else begin
      delay_clamp = diff[TMO_W-1:0];
    end
  end

  // where a finished sift goes back to
  state_t ret_st;
  assign ret_st = (cmd_r == CMD_TICK) ? S_TICK : S_STAT;

  logic [EXP_W-1:0] new_exp;
  assign new_exp = now + EXP_W'(tmo_r);

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      S_CLR:  if (clr_cnt == IW'(ID_SPACE - 1)) state_next = S_IDLE;
      S_IDLE: if (start) state_next = S_LOOK;
      S_LOOK: state_next = S_CHK;
      S_CHK: begin
        case (cmd_r)
          CMD_SCHED: begin
            if (!id_ok)                     state_next = S_STAT;
            else if (found)                 state_next = S_SD;
            else if (int'(count) >= CAPACITY) state_next = S_STAT;
            else                            state_next = S_SU;
          end
          CMD_RESCHED: state_next = found ? S_SD : S_STAT;
          CMD_FIRE:    state_next = found ? S_RM0 : S_STAT;
          CMD_TICK:    state_next = S_TICK;
          default:     state_next = S_STAT;
        endcase
      end
      S_SD: begin
        if (lc_ok)      state_next = S_SD1;
        else if (moved) state_next = ret_st;
        else            state_next = S_SU;
      end
      S_SD1: state_next = rc_ok ? S_SD2 : S_SD3;
      S_SD2: state_next = S_SD3;
      S_SD3: begin
        if (!earlier)   state_next = S_SD;
        else if (moved) state_next = ret_st;
        else            state_next = S_SU;
      end
      S_SU:  state_next = (pos == '0) ? ret_st : S_SU1;
      S_SU1: state_next = earlier ? ret_st : S_SU;
      S_RM0: state_next = (MW'(pos) < count_m1) ? S_RM1 : ret_st;
      S_RM1: state_next = S_SD;
      S_TICK: state_next = (count == '0) ? S_STAT : S_TK1;
      S_TK1:  state_next = due ? S_RM0 : S_STAT;
      S_STAT: state_next = (count != '0) ? S_ST1 : S_IDLE;
      S_ST1:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------- outputs / memory control ----------------
  logic             emit, emit_kind;
  logic [ID_W-1:0]  emit_id;
  logic [TMO_W-1:0] emit_delay;
  logic             put_item, put_cand, put_parent;

  always_comb begin
    heap_raddr = '0;
    map_raddr  = (state == S_IDLE) ? IW'(timer_id) : IW'(id_r);
    emit       = 1'b0;
    emit_kind  = KIND_NOTICE;
    emit_id    = '0;
    emit_delay = '0;
    put_item   = 1'b0;
    put_cand   = 1'b0;
    put_parent = 1'b0;
    case (state)
      S_LOOK: heap_raddr = map_q[AW-1:0];
      S_CHK: begin
        if (cmd_r == CMD_FIRE && found) begin
          emit    = 1'b1;
          emit_id = id_r;
        end
      end
      S_SD: begin
        heap_raddr = lc_w[AW-1:0];
        put_item   = !lc_ok && moved;
      end
      S_SD1: heap_raddr = rc_w[AW-1:0];
      S_SD3: begin
        put_cand = !earlier;
        put_item = earlier && moved;
      end
      S_SU: begin
        heap_raddr = parent;
        put_item   = (pos == '0);
      end
      S_SU1: begin
        put_item   = earlier;
        put_parent = !earlier;
      end
      S_RM0: heap_raddr = count_m1[AW-1:0];
      S_TK1: begin
        if (due) begin
          emit    = 1'b1;
          emit_id = hq_id;
        end
      end
      S_STAT: begin
        if (count == '0) begin
          emit      = 1'b1;
          emit_kind = KIND_STATUS;
        end
      end
      S_ST1: begin
        emit       = 1'b1;
        emit_kind  = KIND_STATUS;
        emit_delay = delay_clamp;
      end
      default: ;
    endcase
  end

  always_comb begin
    heap_we    = put_item || put_cand || put_parent;
    heap_waddr = pos;
    if (put_cand) begin
      heap_wdata = {cand_id, cand_exp};
    end else if (put_parent) begin
      heap_wdata = heap_q;
    end else begin
      heap_wdata = {item_id, item_exp};
    end
    if (state == S_CLR) begin
      map_we    = 1'b1;
      map_waddr = clr_cnt;
      map_wdata = '1;
    end else begin
      map_we    = heap_we;
      map_waddr = IW'(heap_wdata[HW-1:EXP_W]);
      map_wdata = MW'(pos);
    end
  end

  assign busy = (state != S_IDLE);

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_cnt <= '0;
      count   <= '0;
      now     <= '0;
      valid   <= 1'b0;
    end else begin
      state <= state_next;
      valid <= emit;
      case (state)
        S_CLR: clr_cnt <= clr_cnt + IW'(1);
        S_CHK: begin
          case (cmd_r)
            CMD_SCHED: begin
              if (!found && id_ok && int'(count) < CAPACITY) begin
                count <= count + MW'(1);
              end
            end
            CMD_TICK:  now   <= now + EXP_W'(1);
            CMD_CLEAR: count <= '0;
            default: ;
          endcase
        end
        S_RM0: count <= count_m1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    kind          <= emit_kind;
    fired_id      <= emit_id;
    next_delay_ms <= emit_delay;
    queue_empty   <= emit_kind && (count == '0);
    error         <= emit_kind ? err_r : ERR_OK;
    last          <= emit_kind;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_r <= cmd;
          id_r  <= timer_id;
          tmo_r <= timeout_ms;
          err_r <= ERR_OK;
        end
      end
      S_CHK: begin
        item_id  <= id_r;
        item_exp <= new_exp;
        case (cmd_r)
          CMD_SCHED: begin
            if (!id_ok) begin
              err_r <= ERR_UNKNOWN;
            end else if (found) begin
              pos       <= map_q[AW-1:0];
              start_pos <= map_q[AW-1:0];
            end else if (int'(count) >= CAPACITY) begin
              err_r <= ERR_FULL;
            end else begin
              pos       <= AW'(count);
              start_pos <= AW'(count);
            end
          end
          CMD_RESCHED: begin
            if (found) begin
              pos       <= map_q[AW-1:0];
              start_pos <= map_q[AW-1:0];
            end else begin
              err_r <= ERR_UNKNOWN;
            end
          end
          CMD_FIRE: pos <= map_q[AW-1:0];
          default: ;
        endcase
      end
      S_SD1: begin
        cand_id  <= hq_id;
        cand_exp <= hq_exp;
        cand_pos <= lc_w[AW-1:0];
      end
      S_SD2: begin
        if (earlier) begin
          cand_id  <= hq_id;
          cand_exp <= hq_exp;
          cand_pos <= rc_w[AW-1:0];
        end
      end
      S_SD3: if (!earlier) pos <= cand_pos;
      S_SU1: if (!earlier) pos <= parent;
      S_RM1: begin
        item_id   <= hq_id;
        item_exp  <= hq_exp;
        start_pos <= pos;
      end
      S_TK1: if (due) pos <= '0;
      default: ;
    endcase
  end

  // ---------------- assertions ----------------
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= CAPACITY)
    else $error("heap count above capacity");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transaction accepted but block not busy");

  a_status_ends: assert property (@(posedge clk) disable iff (rst)
    (valid && last) |-> (state == S_IDLE))
    else $error("status result shown while sequencer still active");

endmodule

// ----- design/mhtq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mhtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- test/tb.sv -----
// Testbench for the min-heap timer queue: directed and random commands,
// a heap predictor inside a small scoreboard class, and result checking.
// Depends on design/mhtq_pkg.sv and design/min_heap_timer_queue.sv.
`timescale 1ns / 100ps

module tb
  import mhtq_pkg::*;
();

  localparam int CAP        = CAPACITY_DEF;
  localparam int IDS        = ID_SPACE_DEF;
  localparam int N_RANDOM   = 460;
  localparam int CALM_TAIL  = 80;     // final random transactions with no idling
  localparam int CYCLE_CAP  = 3000000;
  localparam int POOL_N     = 40;

  typedef struct packed {
    logic             kind;
    logic [ID_W-1:0]  fired_id;
    logic [TMO_W-1:0] delay;
    logic             empty;
    logic [ERR_W-1:0] err;
    logic             last;
  } timer_result_t;

  // Heap predictor plus the queue of results still owed by the block.
  class heap_tracker;
    logic [ID_W-1:0]  slot_id  [CAP];
    logic [EXP_W-1:0] slot_exp [CAP];
    int               id_slot  [IDS];
    bit               id_live  [IDS];
    int               count;
    logic [EXP_W-1:0] now_ms;
    timer_result_t    owed[$];
    int               fails;

    function new();
      count  = 0;
      now_ms = '0;
      fails  = 0;
      foreach (id_live[i]) id_live[i] = 0;
    endfunction

    function bit earlier(int a, int b);
      logic [EXP_W-1:0] d;
      d = slot_exp[a] - slot_exp[b];
      return d[EXP_W-1];
    endfunction

    function void swap_slots(int a, int b);
      logic [ID_W-1:0]  t;
      logic [EXP_W-1:0] e;
      t = slot_id[a];  e = slot_exp[a];
      slot_id[a] = slot_id[b];  slot_exp[a] = slot_exp[b];
      slot_id[b] = t;           slot_exp[b] = e;
      id_slot[slot_id[a]] = a;
      id_slot[slot_id[b]] = b;
    endfunction

    function void sift_up(int i);
      int p;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (earlier(p, i)) break;
        swap_slots(i, p);
        i = p;
      end
    endfunction

    function bit sift_down(int i);
      int from, c;
      from = i;
      c = i * 2 + 1;
      while (c < count) begin
        if (c + 1 < count && earlier(c + 1, c)) c++;
        if (earlier(i, c)) break;
        swap_slots(i, c);
        i = c;
        c = i * 2 + 1;
      end
      return i != from;
    endfunction

    function void resift(int i);
      if (!sift_down(i)) sift_up(i);
    endfunction

    function void drop_slot(int i);
      logic [ID_W-1:0] gone;
      gone = slot_id[i];
      if (i < count - 1) begin
        swap_slots(i, count - 1);
        count--;
        resift(i);
      end else begin
        count--;
      end
      id_live[gone] = 0;
    endfunction

    function void owe_fire(logic [ID_W-1:0] id);
      timer_result_t r;
      r = '0;
      r.kind = KIND_NOTICE;
      r.fired_id = id;
      owed = {owed, r};
    endfunction

    // Accepted command: update the heap and queue every result it causes.
    function void note_command(logic [CMD_W-1:0] op, logic [ID_W-1:0] id,
                               logic [TMO_W-1:0] tmo);
      timer_result_t    st;
      logic [EXP_W-1:0] d;
      logic [ERR_W-1:0] err;
      int               i;
      err = ERR_OK;
      case (op)
        CMD_SCHED: begin
          if (id_live[id]) begin
            i = id_slot[id];
            slot_exp[i] = now_ms + tmo;
            resift(i);
          end else if (count >= CAP) begin
            err = ERR_FULL;
          end else begin
            i = count;
            slot_id[i] = id;
            slot_exp[i] = now_ms + tmo;
            id_slot[id] = i;
            id_live[id] = 1;
            count++;
            sift_up(i);
          end
        end
        CMD_RESCHED: begin
          if (!id_live[id]) begin
            err = ERR_UNKNOWN;
          end else begin
            i = id_slot[id];
            slot_exp[i] = now_ms + tmo;
            resift(i);
          end
        end
        CMD_FIRE: begin
          if (id_live[id]) begin
            owe_fire(id);
            drop_slot(id_slot[id]);
          end
        end
        CMD_TICK: begin
          now_ms = now_ms + 1;
          while (count > 0) begin
            d = slot_exp[0] - now_ms;
            if (d != 0 && !d[EXP_W-1]) break;
            owe_fire(slot_id[0]);
            drop_slot(0);
          end
        end
        CMD_CLEAR: begin
          count = 0;
          foreach (id_live[k]) id_live[k] = 0;
        end
        default: ;  // undefined codes: status only
      endcase
      st = '0;
      st.kind = KIND_STATUS;
      st.last = 1'b1;
      st.err = err;
      st.empty = (count == 0);
      if (count > 0) begin
        d = slot_exp[0] - now_ms;
        if (d[EXP_W-1])           st.delay = '0;
        else if (d > DELAY_MAX)   st.delay = DELAY_MAX;
        else                      st.delay = d[TMO_W-1:0];
      end
      owed = {owed, st};
    endfunction

    function void check_result(timer_result_t got);
      timer_result_t want;
      if (owed.size() == 0) begin
        $error("result with nothing expected: kind %0d id %0d", got.kind, got.fired_id);
        fails++;
        return;
      end
      want = owed.pop_front();
      if (got.kind != want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind); fails++;
      end
      if (got.fired_id != want.fired_id) begin
        $error("fired_id: expected %0d, got %0d", want.fired_id, got.fired_id); fails++;
      end
      if (got.delay != want.delay) begin
        $error("next_delay_ms: expected %0d, got %0d", want.delay, got.delay); fails++;
      end
      if (got.empty != want.empty) begin
        $error("queue_empty: expected %0d, got %0d", want.empty, got.empty); fails++;
      end
      if (got.err != want.err) begin
        $error("error: expected %0d, got %0d", want.err, got.err); fails++;
      end
      if (got.last != want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last); fails++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [CMD_W-1:0]  cmd = CMD_SCHED;
  logic [ID_W-1:0]   timer_id = '0;
  logic [TMO_W-1:0]  timeout_ms = '0;
  logic              valid;
  logic              kind;
  logic [ID_W-1:0]   fired_id;
  logic [TMO_W-1:0]  next_delay_ms;
  logic              queue_empty;
  logic [ERR_W-1:0]  error;
  logic              last;

  heap_tracker       tracker = new();
  int                cycles = 0;
  logic [ID_W-1:0]   id_pool[POOL_N];

  min_heap_timer_queue dut (
    .clk, .rst, .start, .busy, .cmd, .timer_id, .timeout_ms,
    .valid, .kind, .fired_id, .next_delay_ms, .queue_empty, .error, .last
  );

  always #1 clk = ~clk;

  // Monitor: results first, then the transaction accepted on this edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (valid)
        tracker.check_result({kind, fired_id, next_delay_ms, queue_empty, error, last});
      if (start && !busy)
        tracker.note_command(cmd, timer_id, timeout_ms);
    end
  end

  // Watchdog; generous against the map-clear pass and 33-result ticks.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Present one command and hold it until the block takes it.
  task automatic issue(logic [CMD_W-1:0] op, logic [ID_W-1:0] id, logic [TMO_W-1:0] tmo);
    @(negedge clk);
    start      <= 1'b1;
    cmd        <= op;
    timer_id   <= id;
    timeout_ms <= tmo;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  function automatic logic [TMO_W-1:0] pick_timeout();
    int r;
    r = $urandom_range(99);
    if (r < 80) return TMO_W'($urandom_range(30));
    if (r < 90) return TMO_W'($urandom_range(1000));
    return TMO_W'($urandom);   // all 24 bits
  endfunction

  initial begin
    logic [CMD_W-1:0] op;
    int               r;
    bit               filling;
    foreach (id_pool[i]) id_pool[i] = ID_W'($urandom);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, each command, the named corner cases.
    issue(CMD_SCHED, '0, '0);              // zero timeout: due, waits for a tick
    issue(CMD_SCHED, '1, DELAY_MAX);
    issue(CMD_SCHED, 10'd5, 24'd3);
    issue(CMD_SCHED, 10'd5, 24'd1);        // refresh existing id
    issue(CMD_RESCHED, 10'd700, 24'd9);    // unknown id
    issue(CMD_RESCHED, '1, 24'd2);
    issue(CMD_FIRE, 10'd77, '0);           // unknown id: silent
    issue(CMD_FIRE, '1, '0);
    issue(CMD_TICK, '0, '0);
    issue(CMD_TICK, '0, '0);
    issue(CMD_SCHED, 10'd9, '0);
    issue(CMD_TICK, '0, '0);
    issue(CMD_SCHED, 10'd10, 24'd10);
    issue(CMD_CLEAR, '0, '0);              // now_ms survives
    issue(CMD_CLEAR + 3'd1, 10'd3, 24'd3); // undefined codes
    issue(CMD_CLEAR + 3'd2, '0, '0);
    issue(CMD_CLEAR + 3'd3, '1, DELAY_MAX);
    issue(CMD_SCHED, 10'd10, 24'd2);
    issue(CMD_TICK, '0, '0);
    issue(CMD_RESCHED, 10'd10, '0);
    issue(CMD_TICK, '0, '0);

    // Random: each block of 40 is randomly either heap filling or mixed traffic.
    filling = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 40 == 0) filling = $urandom_range(2) == 0;
      r = $urandom_range(99);
      if (filling) begin
        if      (r < 75) op = CMD_SCHED;
        else if (r < 85) op = CMD_RESCHED;
        else if (r < 92) op = CMD_FIRE;
        else             op = CMD_TICK;
      end else begin
        if      (r < 33) op = CMD_SCHED;
        else if (r < 48) op = CMD_RESCHED;
        else if (r < 62) op = CMD_FIRE;
        else if (r < 94) op = CMD_TICK;
        else if (r < 97) op = CMD_CLEAR;
        else             op = CMD_CLEAR + 3'($urandom_range(1, 3));
      end
      issue(op, ($urandom_range(9) == 0) ? ID_W'($urandom) : id_pool[$urandom_range(POOL_N - 1)],
            pick_timeout());
      if (n < N_RANDOM - CALM_TAIL && $urandom_range(3) == 0)
        pause($urandom_range(1, 14));
    end
    @(negedge clk);
    start <= 1'b0;

    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (tracker.fails == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
